// ----- sv/qec_pkg.sv -----
// Types and constants shared by the quadrature encoder counter files.
package qec_pkg;

  typedef struct packed {
    logic               func;
    logic               pin_a;
    logic               pin_b;
    logic signed [31:0] load_value;
  } qec_in_t;

  typedef struct packed {
    logic signed [31:0] count;
    logic               notify;
  } qec_out_t;

  typedef enum logic [2:0] {
    STG_IDLE      = 3'b001,
    STG_ARMED     = 3'b010,
    STG_SEEN_ZERO = 3'b100
  } stage_t;

  typedef enum logic [2:0] {
    DIR_NONE = 3'b001,
    DIR_CW   = 3'b010,
    DIR_CCW  = 3'b100
  } dir_t;

  // Pin pattern codes, {pin_b, pin_a}
  localparam logic [1:0] PINS_NONE = 2'b00;
  localparam logic [1:0] PINS_A    = 2'b01;
  localparam logic [1:0] PINS_B    = 2'b10;
  localparam logic [1:0] PINS_BOTH = 2'b11;

  localparam logic [31:0] NOTIFY_RESET = 32'hDEADBEEF;

endpackage

// ----- sv/qec_if.sv -----
// Valid/ready channel interfaces for sample items and result items.
interface qec_in_if;
  import qec_pkg::*;
  logic    valid;
  logic    ready;
  qec_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface qec_out_if;
  import qec_pkg::*;
  logic     valid;
  logic     ready;
  qec_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/quadrature_encoder_counter_unit.sv -----
// Quadrature encoder detent counter: top level.
// Channels: sample (sink) takes one item per cycle, either a pin sample of
//   encoder channels A/B (func = 0) or a count load (func = 1, load_value).
//   result (source) returns exactly one item per accepted item: the signed
//   32-bit detent count after that item and a notify flag.
// Result: registered; result.valid rises in the cycle after acceptance.
// Throughput: one item per cycle; the detent machine, count and notify
//   compare update in a single pass into the result register.
// Stall: while a result waits unaccepted, sample.ready follows result.ready,
//   so a new item is taken in the same cycle the held result leaves.
// Reset (rst, synchronous): machine idle, no direction, count 0,
//   last notified value 0xDEADBEEF, no result pending; sample.ready is low
//   while rst is high.
// Notify is raised on a both-high sample when the count differs from the
//   last notified value, which is then updated.
module quadrature_encoder_counter_unit (
  input logic    clk,
  input logic    rst,
  qec_in_if.sink sample,
  qec_out_if.source result
);
  import qec_pkg::*;

  stage_t      stage, stage_next;
  dir_t        direction, direction_next;
  logic [31:0] detent_count, detent_count_next;
  logic [31:0] last_notified, last_notified_next;
  logic        notify_next;
  logic        out_valid;
  qec_out_t    out_data;
  logic        accept;
  logic [1:0]  pins;

  assign sample.ready = !rst && (!out_valid || result.ready);
  assign accept       = sample.valid && sample.ready;
  assign pins         = {sample.data.pin_b, sample.data.pin_a};

  assign result.valid = out_valid;
  assign result.data  = out_data;

  always_comb begin
    stage_next         = stage;
    direction_next     = direction;
    detent_count_next  = detent_count;
    last_notified_next = last_notified;
    notify_next        = 1'b0;
    if (sample.data.func) begin
      detent_count_next = sample.data.load_value;
    end else begin
      case (pins)
        PINS_BOTH: begin
          stage_next     = STG_IDLE;
          direction_next = DIR_NONE;
          if (detent_count != last_notified) begin
            last_notified_next = detent_count;
            notify_next        = 1'b1;
          end
        end
        PINS_NONE: begin
          if (stage == STG_ARMED) begin
            stage_next = STG_SEEN_ZERO;
          end
        end
        default: begin
          if (stage == STG_SEEN_ZERO && direction == DIR_CW && pins == PINS_B) begin
            detent_count_next = detent_count + 32'd1;
            stage_next        = STG_IDLE;
          end else if (stage == STG_SEEN_ZERO && direction == DIR_CCW
                       && pins == PINS_A) begin
            detent_count_next = detent_count - 32'd1;
            stage_next        = STG_IDLE;
          end else begin
            direction_next = (pins == PINS_A) ? DIR_CW : DIR_CCW;
            stage_next     = STG_ARMED;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage         <= STG_IDLE;
      direction     <= DIR_NONE;
      detent_count  <= '0;
      last_notified <= NOTIFY_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        stage         <= stage_next;
        direction     <= direction_next;
        detent_count  <= detent_count_next;
        last_notified <= last_notified_next;
        out_valid     <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.count  <= detent_count_next;
      out_data.notify <= notify_next;
    end
  end

`ifndef SYNTH
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> result.valid)
    else $error("accepted item produced no result");

  a_load_count: assert property (@(posedge clk) disable iff (rst)
    accept && sample.data.func |=> result.data.count == $past(sample.data.load_value))
    else $error("load item did not set the count");

  a_notify_raised: assert property (@(posedge clk) disable iff (rst)
    accept && !sample.data.func && pins == PINS_BOTH && detent_count != last_notified
    |=> result.data.notify && last_notified == result.data.count)
    else $error("changed count not notified");

  a_no_notify_off_both: assert property (@(posedge clk) disable iff (rst)
    accept && (sample.data.func || pins != PINS_BOTH) |=> !result.data.notify)
    else $error("notify raised on an item that is not a both-high sample");
`endif

endmodule
